>>> src/hcbp_pkg.sv
// hcbp_pkg: shared constants, command codes and queue types for the code bit packer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package hcbp_pkg;

  localparam int MAX_CODE_LEN = 32;
  localparam int SYMBOL_COUNT = 256;
  localparam int QUEUE_DEPTH  = 4;

  localparam int CMD_W      = 2;
  localparam int SYM_W      = 8;
  localparam int CODE_LEN_W = 6;
  localparam int CODE_W     = 32;
  localparam int BYTE_W     = 8;
  localparam int PEND_W     = 7;
  localparam int PCNT_W     = 3;

  localparam int SYM_IDX_W = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int ACC_W     = PEND_W + MAX_CODE_LEN;
  localparam int REM_W     = $clog2(ACC_W + 1);
  localparam int QPTR_W    = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [SYM_W:0]        SYMBOL_LIMIT = (SYM_W + 1)'(SYMBOL_COUNT);
  localparam logic [CODE_LEN_W-1:0] LEN_MAX      = CODE_LEN_W'(MAX_CODE_LEN);

  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ENCODE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FLUSH  = 2'd2;

  typedef struct packed {
    logic [CODE_LEN_W-1:0] len;
    logic [CODE_W-1:0]     code;
  } table_entry_t;

  typedef struct packed {
    logic                  flush;
    logic [CODE_LEN_W-1:0] len;
    logic [CODE_W-1:0]     code;
  } q_entry_t;

endpackage

`default_nettype wire

>>> src/hcbp_in_if.sv
// hcbp_in_if: input word channel (valid/ready plus command payload)
// depends on hcbp_pkg
`timescale 1ns / 1ps
`default_nettype none

interface hcbp_in_if import hcbp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CMD_W-1:0]      cmd;
  logic [SYM_W-1:0]      symbol;
  logic [CODE_LEN_W-1:0] code_len;
  logic [CODE_W-1:0]     code_bits;

  modport source (output valid, output cmd, output symbol, output code_len,
                  output code_bits, input ready);
  modport sink (input valid, input cmd, input symbol, input code_len,
                input code_bits, output ready);
endinterface

`default_nettype wire

>>> src/hcbp_out_if.sv
// hcbp_out_if: packed byte output channel (valid/ready plus byte and run marker)
// depends on hcbp_pkg
`timescale 1ns / 1ps
`default_nettype none

interface hcbp_out_if import hcbp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              last_of_run;

  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

`default_nettype wire

>>> src/hcbp_front.sv
// hcbp_front: accepts input words, owns the code table, looks up codes for encode
// depends on hcbp_pkg and hcbp_in_if; feeds the queue toward hcbp_back
`timescale 1ns / 1ps
`default_nettype none

module hcbp_front import hcbp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  hcbp_in_if.sink  in_ch,
  output logic     q_push,
  output q_entry_t q_wdata,
  input  logic     q_full
);

  table_entry_t          mem [SYMBOL_COUNT];
  table_entry_t          rd_entry_r;
  table_entry_t          wr_entry;
  logic [SYMBOL_COUNT-1:0] vld_r;
  logic [SYM_IDX_W-1:0]  idx;
  logic                  accept;
  logic                  in_range;
  logic                  load_we;
  logic                  is_work;
  logic                  hit_r;
  logic                  s1_v_r;
  logic                  s1_v_nxt;
  logic                  s1_flush_r;
  logic [CODE_LEN_W-1:0] len_sat;
  logic [63:0]           mask;

  assign idx      = in_ch.symbol[SYM_IDX_W-1:0];
  assign in_range = {1'b0, in_ch.symbol} < SYMBOL_LIMIT;
  assign accept   = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !s1_v_r || !q_full;
  assign q_push   = s1_v_r && !q_full;

  always_comb begin
    is_work = 1'b0;
    unique case (in_ch.cmd)
      CMD_ENCODE, CMD_FLUSH: is_work = 1'b1;
      default:               is_work = 1'b0;
    endcase
  end

  assign load_we = accept && (in_ch.cmd == CMD_LOAD) && in_range;

  // saturate length and drop bits at or above it
  assign len_sat       = (in_ch.code_len > LEN_MAX) ? LEN_MAX : in_ch.code_len;
  assign mask          = (64'd1 << len_sat) - 64'd1;
  assign wr_entry.len  = len_sat;
  assign wr_entry.code = in_ch.code_bits & mask[CODE_W-1:0];

  always_ff @(posedge clk) begin
    if (load_we) begin
      mem[idx] <= wr_entry;
    end
    if (accept) begin
      rd_entry_r <= mem[idx];
      hit_r      <= vld_r[idx] && in_range;
      s1_flush_r <= (in_ch.cmd == CMD_FLUSH);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (load_we) begin
      vld_r[idx] <= 1'b1;
    end
  end

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (accept) begin
      s1_v_nxt = is_work;
    end else if (q_push) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  // never-loaded entries read as zero length
  assign q_wdata.flush = s1_flush_r;
  assign q_wdata.len   = (hit_r && !s1_flush_r) ? rd_entry_r.len : '0;
  assign q_wdata.code  = (hit_r && !s1_flush_r) ? rd_entry_r.code : '0;

endmodule

`default_nettype wire

>>> src/hcbp_fifo.sv
// hcbp_fifo: short register queue of looked-up codes between front and back
// depends on hcbp_pkg
`timescale 1ns / 1ps
`default_nettype none

module hcbp_fifo import hcbp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t wdata,
  output logic     full,
  input  logic     pop,
  output q_entry_t rdata,
  output logic     empty
);

  q_entry_t            slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_nxt;
  logic [QCNT_W-1:0]   cnt_r;
  logic [QCNT_W-1:0]   cnt_nxt;

  assign full  = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = slots[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr_r] <= wdata;
    end
  end

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

>>> src/hcbp_back.sv
// hcbp_back: msb-first bit packer, one byte per cycle unless the output is stalled, into a registered output word
// depends on hcbp_pkg and hcbp_out_if; drains hcbp_fifo
`timescale 1ns / 1ps
`default_nettype none

module hcbp_back import hcbp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  q_entry_t   q_rdata,
  output logic       q_pop,
  hcbp_out_if.source out_ch
);

  logic [ACC_W-1:0]  acc_r;
  logic [ACC_W-1:0]  acc_nxt;
  logic [REM_W-1:0]  rem_r;
  logic [REM_W-1:0]  rem_nxt;
  logic [REM_W-1:0]  rem_after;
  logic [REM_W-1:0]  sh;
  logic [ACC_W-1:0]  shifted;
  logic [PCNT_W-1:0] cnt;
  logic [PEND_W-1:0] pend;
  logic [BYTE_W-1:0] pmask;
  logic [BYTE_W-1:0] pad;
  logic              emit;
  logic              out_v_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              last_r;

  assign emit      = (rem_r >= REM_W'(BYTE_W)) && (!out_v_r || out_ch.ready);
  assign sh        = rem_r - REM_W'(BYTE_W);
  assign shifted   = acc_r >> sh;
  assign rem_after = emit ? sh : rem_r;
  assign q_pop     = (rem_after < REM_W'(BYTE_W)) && !q_empty;

  // bits left over once the current run is done
  assign cnt   = rem_after[PCNT_W-1:0];
  assign pmask = (BYTE_W'(1) << cnt) - BYTE_W'(1);
  assign pend  = acc_r[PEND_W-1:0] & pmask[PEND_W-1:0];
  assign pad   = BYTE_W'(pend) << (4'(BYTE_W) - {1'b0, cnt});

  always_comb begin
    acc_nxt = acc_r;
    rem_nxt = rem_after;
    if (q_pop) begin
      if (q_rdata.flush) begin
        acc_nxt = ACC_W'(pad);
        rem_nxt = (cnt != '0) ? REM_W'(BYTE_W) : '0;
      end else begin
        acc_nxt = (ACC_W'(pend) << q_rdata.len) | ACC_W'(q_rdata.code);
        rem_nxt = rem_after + REM_W'(q_rdata.len);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      rem_r   <= '0;
      out_v_r <= 1'b0;
    end else begin
      acc_r <= acc_nxt;
      rem_r <= rem_nxt;
      if (emit) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r <= shifted[BYTE_W-1:0];
      last_r     <= (sh < REM_W'(BYTE_W));
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.out_byte    = out_byte_r;
  assign out_ch.last_of_run = last_r;

endmodule

`default_nettype wire

>>> src/huffman_code_bit_packer.sv
// path: front stage register, queue, packer accumulator, then output register
// throughput: one input word per cycle while the queue is not full; loads never
//   reach the packer, which takes a new encode or flush word once under a byte is left
// output rate: one byte per cycle unless stalled, set by the single extraction shifter
// reset: synchronous active-low; table valid bits, queue and pending bits clear at once
`timescale 1ns / 1ps
`default_nettype none

module huffman_code_bit_packer import hcbp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  hcbp_in_if.sink    in_ch,
  hcbp_out_if.source out_ch
);

  q_entry_t q_wdata;
  q_entry_t q_rdata;
  logic     q_push;
  logic     q_pop;
  logic     q_full;
  logic     q_empty;

  hcbp_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_push  (q_push),
    .q_wdata (q_wdata),
    .q_full  (q_full)
  );

  hcbp_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  hcbp_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_rdata (q_rdata),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire

>>> src/hcbp_checker.sv
// hcbp_checker: port-level assertions for huffman_code_bit_packer
// depends on hcbp_pkg; bound to the top level below
`timescale 1ns / 1ps
`default_nettype none

module hcbp_checker import hcbp_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [BYTE_W-1:0] out_byte,
  input logic              last_of_run
);

  // nothing in flight right after reset
  a_out_idle_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("output word valid right after reset");

  // front and queue empty after reset, so input is open
  a_ready_after_reset: assert property (@(posedge clk)
    !rst_n |=> in_ready) else $error("input not ready after reset");

  // any word must cross the front, queue and packer registers, so output stays low
  a_min_latency: assert property (@(posedge clk)
    !rst_n |-> ##2 !out_valid) else $error("output word too early after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last_of_run))
    else $error("stalled output word changed");

endmodule

bind huffman_code_bit_packer hcbp_checker u_hcbp_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_byte    (out_ch.out_byte),
  .last_of_run (out_ch.last_of_run)
);

`default_nettype wire

>>> tb/sv/huffman_code_bit_packer_test.sv
// huffman_code_bit_packer_test: drives load, encode, flush and unused words into the
// code bit packer and checks every packed byte against an in-bench table and bit accumulator
// depends on hcbp_pkg, hcbp_in_if, hcbp_out_if and huffman_code_bit_packer
`timescale 1ns / 1ps

module huffman_code_bit_packer_test import hcbp_pkg::*; ();

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_WORDS = 390;
  localparam int DRAIN_CYCLES = 16;

  typedef struct packed {
    logic [BYTE_W-1:0] byte_value;
    logic              is_last;
  } packed_byte_t;

  class packer_scoreboard;
    logic [CODE_LEN_W-1:0] len_table [SYMBOL_COUNT];
    logic [CODE_W-1:0]     code_table [SYMBOL_COUNT];
    logic [PEND_W-1:0]     pend_bits;
    logic [PCNT_W-1:0]     pend_cnt;
    packed_byte_t          expected_bytes [$];
    int                    errors;

    function new();
      foreach (len_table[i]) begin
        len_table[i]  = '0;
        code_table[i] = '0;
      end
      pend_bits = '0;
      pend_cnt  = '0;
      errors    = 0;
    endfunction

    function int bytes_owed();
      return expected_bytes.size();
    endfunction

    function void add_expected(logic [BYTE_W-1:0] byte_value, logic is_last);
      packed_byte_t item;
      item.byte_value = byte_value;
      item.is_last    = is_last;
      expected_bytes  = {expected_bytes, item};
    endfunction

    function void note_word(logic [CMD_W-1:0] cmd, logic [SYM_W-1:0] sym,
                            logic [CODE_LEN_W-1:0] len, logic [CODE_W-1:0] bits);
      logic [ACC_W-1:0]      acc;
      logic [CODE_LEN_W-1:0] eff_len;
      int                    total;
      case (cmd)
        CMD_LOAD: begin
          eff_len = (len > LEN_MAX) ? LEN_MAX : len;
          len_table[sym]  = eff_len;
          code_table[sym] = CODE_W'(64'(bits) & ((64'd1 << eff_len) - 64'd1));
        end
        CMD_ENCODE: begin
          acc   = (ACC_W'(pend_bits) << len_table[sym]) | ACC_W'(code_table[sym]);
          total = int'(pend_cnt) + int'(len_table[sym]);
          while (total >= BYTE_W) begin
            total -= BYTE_W;
            add_expected(BYTE_W'(acc >> total), (total < BYTE_W));
          end
          pend_bits = PEND_W'(acc & ((ACC_W'(1) << total) - ACC_W'(1)));
          pend_cnt  = PCNT_W'(total);
        end
        CMD_FLUSH: begin
          if (pend_cnt != 0) begin
            add_expected(BYTE_W'(BYTE_W'(pend_bits) << (BYTE_W - int'(pend_cnt))), 1'b1);
          end
          pend_bits = '0;
          pend_cnt  = '0;
        end
        default: ;
      endcase
    endfunction

    function void check_byte(logic [BYTE_W-1:0] byte_value, logic is_last);
      packed_byte_t want;
      if (expected_bytes.size() == 0) begin
        $error("unexpected word: out_byte %02h, last_of_run %0b", byte_value, is_last);
        errors++;
        return;
      end
      want = expected_bytes.pop_front();
      if (byte_value !== want.byte_value) begin
        $error("out_byte: expected %02h, actual %02h", want.byte_value, byte_value);
        errors++;
      end
      if (is_last !== want.is_last) begin
        $error("last_of_run: expected %0b, actual %0b", want.is_last, is_last);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   no_idle;
  int   loaded_syms [$];
  packer_scoreboard sb;

  hcbp_in_if  in_ch ();
  hcbp_out_if out_ch ();

  huffman_code_bit_packer i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
  end

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_byte(out_ch.out_byte, out_ch.last_of_run);
    end
  end

  // starts and ends at a falling edge; valid stays high between back-to-back words
  task automatic send_word(logic [CMD_W-1:0] cmd, logic [SYM_W-1:0] sym,
                           logic [CODE_LEN_W-1:0] len, logic [CODE_W-1:0] bits);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.cmd       <= cmd;
    in_ch.symbol    <= sym;
    in_ch.code_len  <= len;
    in_ch.code_bits <= bits;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_word(cmd, sym, len, bits);
    if (cmd == CMD_LOAD) loaded_syms = {loaded_syms, int'(sym)};
    @(negedge clk);
  endtask

  task automatic load_code(int sym, int len, logic [CODE_W-1:0] bits);
    send_word(CMD_LOAD, SYM_W'(sym), CODE_LEN_W'(len), bits);
  endtask

  task automatic encode(int sym);
    send_word(CMD_ENCODE, SYM_W'(sym), CODE_LEN_W'($urandom), $urandom);
  endtask

  task automatic flush_bits();
    send_word(CMD_FLUSH, SYM_W'($urandom), CODE_LEN_W'($urandom), $urandom);
  endtask

  task automatic wait_drained();
    while (sb.bytes_owed() != 0) @(negedge clk);
  endtask

  task automatic random_word();
    int pick;
    int sym;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      if ($urandom_range(0, 9) < 8) load_code($urandom_range(0, 255), $urandom_range(1, 32),
                                               $urandom);
      else load_code($urandom_range(0, 255), $urandom_range(0, 63), $urandom);
    end else if (pick < 82) begin
      if (loaded_syms.size() > 0 && $urandom_range(0, 9) < 8)
        sym = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
      else
        sym = $urandom_range(0, 255);
      encode(sym);
    end else if (pick < 95) begin
      flush_bits();
    end else begin
      send_word(CMD_UNUSED, SYM_W'($urandom), CODE_LEN_W'($urandom), $urandom);
    end
  endtask

  // result side: stall drawn per word
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    #2000000;
    $display("huffman_code_bit_packer regression: fail");
    $finish;
  end

  initial begin
    sb              = new();
    no_idle         = 1'b0;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.cmd       = CMD_LOAD;
    in_ch.symbol    = '0;
    in_ch.code_len  = '0;
    in_ch.code_bits = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty table, empty flush, unused command
    encode(0);
    flush_bits();
    send_word(CMD_UNUSED, '1, '1, '1);
    // stray bits, full length, saturated length, zero length
    load_code(0, 1, 32'hFFFF_FFFF);
    load_code(255, 32, 32'hFFFF_FFFF);
    load_code(1, 63, 32'hA5A5_5A5A);
    load_code(2, 7, 32'hFFFF_FF55);
    load_code(3, 0, 32'hFFFF_FFFF);
    encode(0);
    encode(2);
    encode(2);
    encode(255);
    encode(3);
    flush_bits();
    encode(1);
    flush_bits();
    load_code(4, 33, 32'h0000_0000);
    encode(4);
    encode(0);
    flush_bits();
    load_code(5, 8, 32'h0000_00C3);
    encode(5);
    encode(200);

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i % 60 == 30) no_idle = ~no_idle;
      if (i == RANDOM_WORDS / 2) begin
        in_ch.valid <= 1'b0;
        wait_drained();
      end
      random_word();
    end
    flush_bits();
    in_ch.valid <= 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.errors == 0) begin
      $display("huffman_code_bit_packer regression: pass");
    end else begin
      $display("huffman_code_bit_packer regression: fail");
    end
    $finish;
  end

endmodule
